>>> rtl/tms_pkg.sv
package tms_pkg;

  localparam logic [2:0] OP_LOAD_RULE  = 3'd0;
  localparam logic [2:0] OP_WRITE_TAPE = 3'd1;
  localparam logic [2:0] OP_SET_ACCEPT = 3'd2;
  localparam logic [2:0] OP_RUN        = 3'd3;
  localparam logic [2:0] OP_READ_TAPE  = 3'd4;

  localparam logic [2:0] REG_START    = 3'd0;
  localparam logic [2:0] REG_BLANK    = 3'd1;
  localparam logic [2:0] REG_CROSSED  = 3'd2;
  localparam logic [2:0] REG_WILDCARD = 3'd3;
  localparam logic [2:0] REG_LIMIT    = 3'd4;

  localparam logic [1:0] HALT_ACCEPT = 2'd0;
  localparam logic [1:0] HALT_NORULE = 2'd1;
  localparam logic [1:0] HALT_OFF    = 2'd2;
  localparam logic [1:0] HALT_LIMIT  = 2'd3;

  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;

  localparam logic [7:0] PLUS_CHAR   = 8'h2B;
  localparam logic [7:0] EQUALS_CHAR = 8'h3D;

endpackage

>>> rtl/turing_machine_stepper.sv
// Sequencing: load, write and accept items are handled in idle; a read item goes through the
// result wait state to the output, where it is held until taken. One item is handled at a time.
// A run checks the step limit and reads the tape (check, tape read, tape wait), then scans the rule
// slots (read wait, evaluate) up to the matching one; after it stops, final and result wait follow.
// Reset: synchronous, active high; the tape is cleared by a sweep over all TAPE_CELLS cells
// after reset, during which no item is accepted. Rules start invalid via valid bits.
module turing_machine_stepper #(
  parameter int NUM_STATES      = 16,
  parameter int RULES_PER_STATE = 8,
  parameter int TAPE_CELLS      = 1024,
  parameter int SYMBOL_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0], rule_state[6:3], rule_slot[9:7], rule_valid[10], match_symbol[18:11],
  // target_state[22:19], replace_symbol[30:23], head_move[32:31], cell_address[42:33],
  // cell_symbol[50:43], accept_flag[51], zero fill up to bit 55
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted[0], halt_reason[2:1], steps_taken[34:3], final_state[38:35],
  // final_head[48:39], read_symbol[56:49], zero fill up to bit 63
  output logic [63:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SB  = SYMBOL_BITS;
  localparam int SLW = (RULES_PER_STATE > 1) ? $clog2(RULES_PER_STATE) : 1;
  localparam int STW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int TW  = $clog2(TAPE_CELLS);
  localparam int NR  = NUM_STATES * RULES_PER_STATE;
  localparam int RW  = $clog2(NR);
  localparam int EW  = SB + 4 + SB + 2;
  localparam logic [SB-1:0] SYM_MASK = {SB{1'b1}};

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TWAIT = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_FWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  fsm;
  logic [3:0]  init_state;
  logic [7:0]  blank_symbol, crossed_symbol, wildcard_symbol;
  logic [31:0] step_limit;

  // Memories.
  logic [EW-1:0] rule_mem [NR];
  logic [NR-1:0] rule_vld;
  logic [EW-1:0] rule_q;
  logic          rule_vq;
  logic [SB-1:0] tape_mem [TAPE_CELLS];
  logic [SB-1:0] tape_q;
  logic [NUM_STATES-1:0] accept_set;

  logic [3:0]     machine_state;
  logic [TW-1:0]  head_position;
  logic [31:0]    step_count;
  logic [SLW:0]   slot;
  logic [SB-1:0]  cur_sym;
  logic [TW:0]    clr_cnt;
  logic           is_read;
  logic [1:0]     reason;
  logic [63:0]    out_data;
  logic           addr_ok_q;

  // Input field decode.
  logic [2:0]  in_op;
  logic [3:0]  in_rs, in_target;
  logic [2:0]  in_slot;
  logic [7:0]  in_match, in_replace, in_csym;
  logic [1:0]  in_move;
  logic [9:0]  in_addr;
  assign in_op      = s_tdata[2:0];
  assign in_rs      = s_tdata[6:3];
  assign in_slot    = s_tdata[9:7];
  assign in_match   = s_tdata[18:11];
  assign in_target  = s_tdata[22:19];
  assign in_replace = s_tdata[30:23];
  assign in_move    = s_tdata[32:31];
  assign in_addr    = s_tdata[42:33];
  assign in_csym    = s_tdata[50:43];

  assign s_tready  = (fsm == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (fsm == S_OUT);
  assign m_tdata   = out_data;

  logic in_fire;
  assign in_fire = s_tvalid && s_tready;

  logic load_ok, tape_wr_ok, addr_ok;
  assign load_ok    = ({24'd0, in_rs} < 32'(NUM_STATES)) &&
                      ({29'd0, in_slot} < 32'(RULES_PER_STATE));
  assign addr_ok    = ({22'd0, in_addr} < 32'(TAPE_CELLS));
  assign tape_wr_ok = addr_ok;

  // Rule entry fields from the registered read.
  logic [SB-1:0] r_match, r_replace;
  logic [3:0]    r_target;
  logic [1:0]    r_move;
  assign {r_match, r_target, r_replace, r_move} = rule_q;

  logic state_ok;
  assign state_ok = ({28'd0, machine_state} < 32'(NUM_STATES));

  logic reserved, hit;
  assign reserved = (cur_sym == (blank_symbol[SB-1:0] & SYM_MASK)) ||
                    (cur_sym == (crossed_symbol[SB-1:0] & SYM_MASK)) ||
                    (cur_sym == (wildcard_symbol[SB-1:0] & SYM_MASK)) ||
                    (cur_sym == (tms_pkg::PLUS_CHAR[SB-1:0] & SYM_MASK)) ||
                    (cur_sym == (tms_pkg::EQUALS_CHAR[SB-1:0] & SYM_MASK));
  assign hit = rule_vq && ((r_match == (wildcard_symbol[SB-1:0] & SYM_MASK)) ?
                           !reserved : (r_match == cur_sym));

  logic [RW-1:0] rd_addr;
  assign rd_addr = RW'(machine_state[STW-1:0] * RULES_PER_STATE) + RW'(slot[SLW-1:0]);

  // Step evaluation after a hit.
  logic          off;
  logic [TW-1:0] head_next;
  logic          acc_next;
  always_comb begin
    off = 1'b0;
    head_next = head_position;
    if (r_move == tms_pkg::MOVE_RIGHT) begin
      if (head_position == TW'(TAPE_CELLS - 1)) off = 1'b1;
      else head_next = head_position + 1'b1;
    end else if (r_move == tms_pkg::MOVE_LEFT) begin
      if (head_position == '0) off = 1'b1;
      else head_next = head_position - 1'b1;
    end
    acc_next = ({28'd0, r_target} < 32'(NUM_STATES)) && accept_set[r_target[STW-1:0]];
  end

  // Tape memory port: one write and one read address per cycle.
  logic          tp_we;
  logic [TW-1:0] tp_wa, tp_ra;
  logic [SB-1:0] tp_wd;
  always_comb begin
    tp_we = 1'b0;
    tp_wa = head_position;
    tp_wd = r_replace;
    tp_ra = head_position;
    if (fsm == S_CLEAR) begin
      tp_we = 1'b1;
      tp_wa = clr_cnt[TW-1:0];
      tp_wd = '0;
    end else if (in_fire && in_op == tms_pkg::OP_WRITE_TAPE && tape_wr_ok) begin
      tp_we = 1'b1;
      tp_wa = in_addr[TW-1:0];
      tp_wd = in_csym[SB-1:0];
    end else if (fsm == S_EVAL && hit && r_replace != '0) begin
      tp_we = 1'b1;
    end
    if (in_fire) tp_ra = in_addr[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (tp_we) tape_mem[tp_wa] <= tp_wd;
    tape_q <= tape_mem[tp_ra];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == tms_pkg::OP_LOAD_RULE && load_ok) begin
      rule_mem[RW'(in_rs[STW-1:0] * RULES_PER_STATE) + RW'(in_slot[SLW-1:0])] <=
        {in_match[SB-1:0], in_target, in_replace[SB-1:0], in_move};
    end
    rule_q <= rule_mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_state <= 4'd0;
      blank_symbol <= 8'd0;
      crossed_symbol <= 8'd88;
      wildcard_symbol <= 8'd42;
      step_limit <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tms_pkg::REG_START:    init_state <= cfg_data[3:0];
        tms_pkg::REG_BLANK:    blank_symbol <= cfg_data[7:0];
        tms_pkg::REG_CROSSED:  crossed_symbol <= cfg_data[7:0];
        tms_pkg::REG_WILDCARD: wildcard_symbol <= cfg_data[7:0];
        tms_pkg::REG_LIMIT:    step_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_CLEAR;
      clr_cnt <= '0;
      rule_vld <= '0;
      accept_set <= '0;
      rule_vq <= 1'b0;
      machine_state <= 4'd0;
      head_position <= '0;
      step_count <= 32'd0;
      slot <= '0;
      is_read <= 1'b0;
      reason <= tms_pkg::HALT_ACCEPT;
    end else begin
      rule_vq <= rule_vld[rd_addr];
      unique case (fsm)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (TW+1)'(TAPE_CELLS - 1)) fsm <= S_IDLE;
        end
        S_IDLE: if (in_fire) begin
          unique case (in_op)
            tms_pkg::OP_LOAD_RULE: if (load_ok)
              rule_vld[RW'(in_rs[STW-1:0] * RULES_PER_STATE) + RW'(in_slot[SLW-1:0])]
                <= s_tdata[10];
            tms_pkg::OP_SET_ACCEPT: if ({28'd0, in_rs} < 32'(NUM_STATES))
              accept_set[in_rs[STW-1:0]] <= s_tdata[51];
            tms_pkg::OP_RUN: begin
              machine_state <= init_state;
              head_position <= '0;
              step_count <= 32'd0;
              is_read <= 1'b0;
              fsm <= S_CHECK;
            end
            tms_pkg::OP_READ_TAPE: begin
              is_read <= 1'b1;
              fsm <= S_FWAIT;
            end
            default: ;
          endcase
        end
        S_CHECK: begin
          if ((step_limit != 32'd0 && step_count >= step_limit) ||
              step_count == 32'hFFFF_FFFF) begin
            reason <= tms_pkg::HALT_LIMIT;
            fsm <= S_FIN;
          end else if (!state_ok) begin
            reason <= tms_pkg::HALT_NORULE;
            fsm <= S_FIN;
          end else begin
            fsm <= S_TRD;
          end
        end
        S_TRD:   fsm <= S_TWAIT;
        S_TWAIT: begin
          cur_sym <= tape_q;
          slot <= '0;
          fsm <= S_SCAN;
        end
        S_SCAN:  fsm <= S_RWAIT;
        S_RWAIT: fsm <= S_EVAL;
        S_EVAL: begin
          if (hit) begin
            head_position <= head_next;
            machine_state <= r_target;
            step_count <= step_count + 1'b1;
            if (acc_next) begin
              reason <= tms_pkg::HALT_ACCEPT;
              fsm <= S_FIN;
            end else if (off) begin
              reason <= tms_pkg::HALT_OFF;
              fsm <= S_FIN;
            end else begin
              fsm <= S_CHECK;
            end
          end else if (slot == (SLW+1)'(RULES_PER_STATE - 1)) begin
            reason <= tms_pkg::HALT_NORULE;
            fsm <= S_FIN;
          end else begin
            slot <= slot + 1'b1;
            fsm <= S_RWAIT;
          end
        end
        S_FIN:   fsm <= S_FWAIT;
        S_FWAIT: fsm <= S_OUT;
        S_OUT:   if (m_tready) fsm <= S_IDLE;
        default: fsm <= S_IDLE;
      endcase
    end
  end

  // Result register, loaded once the tape read is back.
  always_ff @(posedge clk) begin
    if (fsm == S_FWAIT) begin
      out_data <= '0;
      if (is_read) begin
        out_data[56:49] <= addr_ok_q ? 8'(tape_q) : 8'd0;
      end else begin
        out_data[0]     <= (reason == tms_pkg::HALT_ACCEPT);
        out_data[2:1]   <= reason;
        out_data[34:3]  <= step_count;
        out_data[38:35] <= machine_state;
        out_data[48:39] <= 10'(head_position);
        out_data[56:49] <= 8'(tape_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) addr_ok_q <= addr_ok;
  end

endmodule

>>> bench/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] rule_state;
    logic [2:0] rule_slot;
    logic       rule_valid;
    logic [7:0] match_symbol;
    logic [3:0] target_state;
    logic [7:0] replace_symbol;
    logic [1:0] head_move;
    logic [9:0] cell_address;
    logic [7:0] cell_symbol;
    logic       accept_flag;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  halt_reason;
    logic [31:0] steps_taken;
    logic [3:0]  final_state;
    logic [9:0]  final_head;
    logic [7:0]  read_symbol;
  } outcome_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] match;
    logic [3:0] target;
    logic [7:0] replace;
    logic [1:0] move;
  } rule_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  turing_machine_stepper dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the machine used to predict results.
  rule_t       rules [16][8];
  logic [7:0]  tape [1024];
  logic [15:0] accepting;
  logic [3:0]  start_st;
  logic [7:0]  blank_sym, crossed_sym, wild_sym;
  logic [31:0] limit_steps;

  item_t    pending_q[$];
  outcome_t outcome_q[$];
  item_t    cur_item;
  int       mismatches = 0;
  int       cyc = 0;

  function automatic logic is_reserved(logic [7:0] s);
    return s == blank_sym || s == crossed_sym || s == wild_sym ||
           s == tms_pkg::PLUS_CHAR || s == tms_pkg::EQUALS_CHAR;
  endfunction

  // Apply one accepted item to the shadow machine and queue any result.
  function automatic void tm_predict(item_t it);
    outcome_t   o;
    logic [3:0] st;
    int         hd, k, hit;
    logic       off;
    logic [1:0] why;
    logic [31:0] n;
    o = '0;
    case (it.opcode)
      tms_pkg::OP_LOAD_RULE: rules[it.rule_state][it.rule_slot] =
        '{it.rule_valid, it.match_symbol, it.target_state, it.replace_symbol, it.head_move};
      tms_pkg::OP_WRITE_TAPE: tape[it.cell_address] = it.cell_symbol;
      tms_pkg::OP_SET_ACCEPT: accepting[it.rule_state] = it.accept_flag;
      tms_pkg::OP_READ_TAPE: begin
        o.read_symbol = tape[it.cell_address];
        outcome_q.push_back(o);
      end
      tms_pkg::OP_RUN: begin
        st = start_st;
        hd = 0;
        n = 0;
        forever begin
          if ((limit_steps != 0 && n >= limit_steps) || n == 32'hFFFF_FFFF) begin
            why = tms_pkg::HALT_LIMIT;
            break;
          end
          hit = -1;
          for (k = 0; k < 8 && hit < 0; k++) begin
            if (rules[st][k].valid) begin
              if (rules[st][k].match == wild_sym) begin
                if (!is_reserved(tape[hd])) hit = k;
              end else if (rules[st][k].match == tape[hd]) begin
                hit = k;
              end
            end
          end
          if (hit < 0) begin
            why = tms_pkg::HALT_NORULE;
            break;
          end
          off = 1'b0;
          if (rules[st][hit].replace != 0) tape[hd] = rules[st][hit].replace;
          if (rules[st][hit].move == tms_pkg::MOVE_RIGHT) begin
            if (hd == 1023) off = 1'b1;
            else hd++;
          end else if (rules[st][hit].move == tms_pkg::MOVE_LEFT) begin
            if (hd == 0) off = 1'b1;
            else hd--;
          end
          st = rules[st][hit].target;
          n++;
          if (accepting[st]) begin
            why = tms_pkg::HALT_ACCEPT;
            break;
          end
          if (off) begin
            why = tms_pkg::HALT_OFF;
            break;
          end
        end
        o.accepted = (why == tms_pkg::HALT_ACCEPT);
        o.halt_reason = why;
        o.steps_taken = n;
        o.final_state = st;
        o.final_head = hd[9:0];
        o.read_symbol = tape[hd];
        outcome_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [55:0] pack_item(item_t it);
    return {4'b0, it.accept_flag, it.cell_symbol, it.cell_address, it.head_move,
            it.replace_symbol, it.target_state, it.match_symbol, it.rule_valid,
            it.rule_slot, it.rule_state, it.opcode};
  endfunction

  // Driver: bursts of items separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tm_predict(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          s_tdata <= pack_item(cur_item);
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    s_tvalid <= nv;
  end

  // Monitor: receiver stalls follow a pattern that changes now and then.
  logic [15:0] stall_pat = 16'hFFFF;
  always @(posedge clk) begin
    outcome_t got, want;
    cyc <= cyc + 1;
    if (cyc % 400 == 0)
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    m_tready <= stall_pat[cyc % 16];
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[2:1], m_tdata[34:3], m_tdata[38:35], m_tdata[48:39],
             m_tdata[56:49]};
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %h", got);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: acc %b/%b why %0d/%0d steps %0d/%0d st %0d/%0d ",
                      "hd %0d/%0d sym %h/%h"},
                     want.accepted, got.accepted, want.halt_reason, got.halt_reason,
                     want.steps_taken, got.steps_taken, want.final_state, got.final_state,
                     want.final_head, got.final_head, want.read_symbol, got.read_symbol);
        end
      end
    end
    if (cyc > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Holds the write on the channel until it is taken; the caller drops valid afterwards.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tms_pkg::REG_START:    start_st = val[3:0];
      tms_pkg::REG_BLANK:    blank_sym = val[7:0];
      tms_pkg::REG_CROSSED:  crossed_sym = val[7:0];
      tms_pkg::REG_WILDCARD: wild_sym = val[7:0];
      tms_pkg::REG_LIMIT:    limit_steps = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [3:0] s, logic [7:0] b, logic [7:0] c, logic [7:0] w,
                          logic [31:0] l);
    write_reg(tms_pkg::REG_START, 32'(s));
    write_reg(tms_pkg::REG_BLANK, 32'(b));
    write_reg(tms_pkg::REG_CROSSED, 32'(c));
    write_reg(tms_pkg::REG_WILDCARD, 32'(w));
    write_reg(tms_pkg::REG_LIMIT, l);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every item is accepted and every result has arrived.
  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || outcome_q.size() > 0) @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic item_t mk(logic [2:0] op, logic [3:0] st, logic [2:0] slot,
                               logic v, logic [7:0] m, logic [3:0] t, logic [7:0] r,
                               logic [1:0] mv, logic [9:0] a, logic [7:0] cs, logic af);
    return '{op, st, slot, v, m, t, r, mv, a, cs, af};
  endfunction

  // Symbols biased toward the reserved codes and a small working alphabet.
  function automatic logic [7:0] pick_sym();
    case ($urandom_range(0, 9))
      0: return blank_sym;
      1: return crossed_sym;
      2: return wild_sym;
      3: return tms_pkg::PLUS_CHAR;
      4: return tms_pkg::EQUALS_CHAR;
      5: return 8'h23;
      6: return 8'h61;
      7: return 8'h62;
      8: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_state();
    return 4'(($urandom_range(0, 4) == 0) ? $urandom : start_st + $urandom_range(0, 3));
  endfunction

  // Small machines with random content, runs and read-backs, plus some noise.
  task automatic random_programs(int count);
    item_t it;
    int n, j;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        it = item_t'(52'({$urandom, $urandom}));
        it.opcode = 3'($urandom_range(0, 7));
        it.match_symbol = 8'($urandom);
        it.replace_symbol = 8'($urandom);
        it.cell_symbol = 8'($urandom);
        pending_q.push_back(it);
        n++;
        continue;
      end
      repeat ($urandom_range(2, 10)) begin
        pending_q.push_back(mk(tms_pkg::OP_LOAD_RULE, pick_state(), 3'($urandom),
          $urandom_range(0, 4) != 0, pick_sym(), pick_state(),
          ($urandom_range(0, 2) == 0) ? 8'h00 : pick_sym(), 2'($urandom), 0, 0, 0));
        n++;
      end
      repeat ($urandom_range(0, 2)) begin
        pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, pick_state(), 0, 0, 0, 0, 0, 0, 0, 0,
                               $urandom_range(0, 2) == 0));
        n++;
      end
      repeat ($urandom_range(0, 6)) begin
        pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0,
                               10'($urandom_range(0, 15)), pick_sym(), 0));
        n++;
      end
      pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      n++;
      for (j = 0; j < $urandom_range(0, 3); j++) begin
        pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0,
          10'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15)), 0, 0));
        n++;
      end
    end
  endtask

  // With no step limit every rule moves right, so each run ends at the tape edge at latest.
  task automatic right_only_programs();
    int s, k;
    for (s = 0; s < 16; s++)
      for (k = 0; k < 8; k++)
        pending_q.push_back(mk(tms_pkg::OP_LOAD_RULE, 4'(s), 3'(k), $urandom_range(0, 3) != 0,
                               pick_sym(), 4'($urandom), pick_sym(), tms_pkg::MOVE_RIGHT,
                               0, 0, 0));
    repeat (5) begin
      repeat (6) pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0,
                                        10'($urandom_range(0, 40)), pick_sym(), 0));
      pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, 4'($urandom), 0, 0, 0, 0, 0, 0, 0, 0,
                             1'($urandom)));
      pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0, 10'($urandom), 0, 0));
    end
  endtask

  initial begin
    int s, k;
    for (s = 0; s < 16; s++)
      for (k = 0; k < 8; k++) rules[s][k] = '0;
    for (s = 0; s < 1024; s++) tape[s] = '0;
    accepting = '0;
    start_st = 0;
    blank_sym = 0;
    crossed_sym = 8'd88;
    wild_sym = 8'd42;
    limit_steps = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings.
    pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Left move at cell zero writes and steps, then falls off the tape.
    pending_q.push_back(mk(tms_pkg::OP_LOAD_RULE, 0, 0, 1, 8'h00, 1, 8'h23,
                           tms_pkg::MOVE_LEFT, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Wildcard rule with move code three, which acts as stay.
    pending_q.push_back(mk(tms_pkg::OP_LOAD_RULE, 0, 1, 1, 8'd42, 1, 8'h00, 2'd3, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // A plus sign is reserved, so the wildcard skips it.
    pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0, 0,
                           tms_pkg::PLUS_CHAR, 0));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0, 0,
                           tms_pkg::EQUALS_CHAR, 0));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Start state accepting still steps once; accept wins over falling off.
    pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
    pending_q.push_back(mk(tms_pkg::OP_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_WRITE_TAPE, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 8'hFF, 0));
    pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_SET_ACCEPT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back('1);
    pending_q.push_back(mk(tms_pkg::OP_LOAD_RULE, 4'hF, 3'h7, 0, 8'hFF, 4'hF, 8'hFF, 2'd3,
                           0, 0, 0));
    pending_q.push_back(mk(tms_pkg::OP_READ_TAPE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Several register settings, extremes included.
    set_regs(0, 0, 88, 42, 40);
    random_programs(250);
    drain();
    set_regs(3, 8'hFF, 8'h00, 8'hFF, 1);
    random_programs(200);
    drain();
    set_regs(4'hF, 8'h23, 8'hFF, 8'h00, 64);
    random_programs(250);
    drain();
    set_regs(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             32'($urandom_range(1, 100)));
    random_programs(250);
    drain();
    set_regs(0, 0, 88, 42, 0);
    right_only_programs();
    drain();
    set_regs(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 32'hFFFF_FFFF);
    right_only_programs();
    drain();

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
